### hw/rtl/baro_altitude_velocity_filter_top_assert.svh
// Assertion macros shared by the checker of the barometric altitude filter.
// Both expect the clock to be visible as i_clk; BAVF_ASSERT also expects the reset as i_rst_n.
`ifndef BARO_ALTITUDE_VELOCITY_FILTER_TOP_ASSERT_SVH
`define BARO_ALTITUDE_VELOCITY_FILTER_TOP_ASSERT_SVH

// Property checked on every rising edge outside reset.
`define BAVF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Property checked on every rising edge, reset included.
`define BAVF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### hw/rtl/bavf_pkg.sv
`timescale 1ns / 1ps

package bavf_pkg;

    // Field widths of the request and result channels.
    localparam int PRESSURE_W = 23;
    localparam int TEMP_W     = 16;
    localparam int ELAPSED_W  = 24;
    localparam int RESULT_W   = 32;

    // Sea level pressure in 1/64 Pa.
    localparam logic [PRESSURE_W-1:0] SEA_LEVEL_64THS_PA = 23'd6489600;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 38;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Shared divider: two quotient bits per cycle.
    localparam int DIV_NUM_W = 54;
    localparam int DIV_DEN_W = 24;
    localparam int DIV_STEPS = DIV_NUM_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Saturation limits held at the width of the values that sat_s32 takes in.
    localparam int WIDE_W = 56;
    localparam logic signed [WIDE_W-1:0] S32_MAX = 56'sd2147483647;
    localparam logic signed [WIDE_W-1:0] S32_MIN = -56'sd2147483648;

    // Sequencer steps, in the order an item goes through them.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_Q_DIV,
        ST_Q_WAIT,
        ST_SQ_MUL,
        ST_SQ_CAP,
        ST_CU_MUL,
        ST_CU_CAP,
        ST_CT_MUL,
        ST_CT_DIV,
        ST_CT_WAIT,
        ST_OFS,
        ST_REL,
        ST_ALT,
        ST_DIFF,
        ST_V_MUL,
        ST_V_DIV,
        ST_V_WAIT,
        ST_R1_MUL,
        ST_R1_CAP,
        ST_R2_MUL,
        ST_R2_CAP,
        ST_R_DIV,
        ST_R_WAIT,
        ST_OUT
    } t_state;

    // Clamp a wide signed value to the signed 32 bit range.
    function automatic logic signed [RESULT_W-1:0] sat_s32(input logic signed [WIDE_W-1:0] x);
        logic signed [RESULT_W-1:0] y;
        if (x > S32_MAX) begin
            y = S32_MAX[RESULT_W-1:0];
        end else if (x < S32_MIN) begin
            y = S32_MIN[RESULT_W-1:0];
        end else begin
            y = x[RESULT_W-1:0];
        end
        return y;
    endfunction

    // Magnitude of a signed 32 bit value; the most negative value maps to 2^31.
    function automatic logic [RESULT_W-1:0] abs32(input logic signed [RESULT_W-1:0] x);
        logic [RESULT_W-1:0] y;
        if (x[RESULT_W-1]) begin
            y = $unsigned(-x);
        end else begin
            y = $unsigned(x);
        end
        return y;
    endfunction

endpackage

### hw/rtl/bavf_stream_if.sv
`timescale 1ns / 1ps

// Sample request channel: pressure, temperature and elapsed time.
interface bavf_in_if;
    import bavf_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [PRESSURE_W-1:0]       pressure;
    logic signed [TEMP_W-1:0]    temperature;
    logic [ELAPSED_W-1:0]        elapsed_us;

    modport source (output valid, output pressure, output temperature, output elapsed_us,
                    input ready);
    modport sink   (input valid, input pressure, input temperature, input elapsed_us,
                    output ready);
endinterface

// Result channel: filtered altitude, climb rate and the sample's temperature.
interface bavf_out_if;
    import bavf_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [RESULT_W-1:0]  altitude;
    logic signed [RESULT_W-1:0]  climb_rate;
    logic signed [TEMP_W-1:0]    temperature_out;

    modport source (output valid, output altitude, output climb_rate, output temperature_out,
                    input ready);
    modport sink   (input valid, input altitude, input climb_rate, input temperature_out,
                    output ready);
endinterface

### hw/rtl/baro_altitude_velocity_filter_top.sv
`timescale 1ns / 1ps

// Barometric altitude and climb rate filter.
// i_sample carries one pressure sample (1/64 Pa), its temperature and the
// microseconds since the previous sample; an elapsed time of zero counts as one.
// o_result carries the filtered relative altitude (1/16 cm), the filtered climb
// rate (1/16 cm per second), both saturated to 32 bits, and the temperature.
// One sample is worked on at a time. A sequencer drives a shared 38 x 24 bit
// multiplier and a shared divider that retires two quotient bits per cycle.
// The result is loaded into the output register as the sequencer goes back to
// idle, and the next sample can be taken in the cycle after that. Most of the
// time is spent in the four divider passes.
// While a result waits in the output register, i_sample.ready still accepts the
// next sample; if the receiver is still stalling when that sample is finished,
// the sequencer holds it until the output register is free.
// A synchronous reset clears the altitude offset, both filters and the previous
// altitude to zero and empties the output register.
module baro_altitude_velocity_filter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bavf_in_if.sink     i_sample,
    bavf_out_if.source  o_result
);
    import bavf_pkg::*;

    t_state r_state, n_state;

    // Working registers of the current sample.
    logic [PRESSURE_W-1:0]       r_m, n_m;
    logic                        r_neg, n_neg;
    logic [ELAPSED_W-1:0]        r_dt, n_dt;
    logic signed [TEMP_W-1:0]    r_temp, n_temp;
    logic [PRESSURE_W-1:0]       r_q, n_q;
    logic [29:0]                 r_s, n_s;
    logic [36:0]                 r_c, n_c;
    logic signed [25:0]          r_raw, n_raw;
    logic signed [33:0]          r_rel, n_rel;
    logic                        r_vneg, n_vneg;
    logic [32:0]                 r_md, n_md;
    logic signed [RESULT_W-1:0]  r_v, n_v;
    logic signed [39:0]          r_acc, n_acc;
    logic                        r_rneg, n_rneg;

    // Filter state.
    logic signed [RESULT_W-1:0]  r_ofs, n_ofs;
    logic signed [RESULT_W-1:0]  r_fa, n_fa;
    logic signed [RESULT_W-1:0]  r_prev, n_prev;
    logic signed [RESULT_W-1:0]  r_fr, n_fr;

    // Output register.
    logic                        r_out_valid, n_out_valid;
    logic signed [RESULT_W-1:0]  r_out_alt, n_out_alt;
    logic signed [RESULT_W-1:0]  r_out_rate, n_out_rate;
    logic signed [TEMP_W-1:0]    r_out_temp, n_out_temp;

    // Shared units.
    logic [MUL_A_W-1:0]    mul_a;
    logic [MUL_B_W-1:0]    mul_b;
    logic [MUL_P_W-1:0]    mul_p;
    logic                  div_start;
    logic [DIV_NUM_W-1:0]  div_num;
    logic [DIV_DEN_W-1:0]  div_den;
    logic                  div_done;
    logic [DIV_NUM_W-1:0]  div_quot;

    // Intermediate values.
    logic                        in_gt;
    logic [PRESSURE_W-1:0]       in_m;
    logic [25:0]                 m9;
    logic [25:0]                 lin_sum;
    logic [23:0]                 lin;
    logic [24:0]                 raw_mag;
    logic [MUL_P_W-1:0]          p_rnd;
    logic signed [33:0]          ofs_sum;
    logic signed [33:0]          rel_val;
    logic signed [34:0]          alt_sum;
    logic signed [33:0]          alt_half;
    logic signed [32:0]          diff;
    logic [DIV_NUM_W-1:0]        q_num;
    logic [DIV_NUM_W-1:0]        ct_num;
    logic [DIV_NUM_W-1:0]        v_num;
    logic signed [WIDE_W-1:0]    q_pos;
    logic signed [WIDE_W-1:0]    q_negv;
    logic [39:0]                 acc_abs;
    logic signed [39:0]          p_term;
    logic [RESULT_W-1:0]         fr_abs;
    logic [RESULT_W-1:0]         v_abs;

    bavf_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    bavf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Pressure deficit magnitude and sign.
    assign in_gt = i_sample.pressure > SEA_LEVEL_64THS_PA;
    assign in_m  = in_gt ? (i_sample.pressure - SEA_LEVEL_64THS_PA)
                         : (SEA_LEVEL_64THS_PA - i_sample.pressure);

    // Linear term 9*m/4, rounded half up.
    assign m9      = {3'd0, r_m} + {r_m, 3'd0};
    assign lin_sum = m9 + 26'd2;
    assign lin     = lin_sum[25:2];
    assign raw_mag = {1'b0, div_quot[23:0]} + {1'b0, lin};

    // Q16 rounding of a product before the shift by 16.
    assign p_rnd = mul_p + MUL_P_W'(32768);

    // Dividends for three of the four divider passes; the rate pass forms its own.
    assign q_num  = {21'd0, r_m, 10'd0} + DIV_NUM_W'(500);
    assign ct_num = mul_p[DIV_NUM_W-1:0] + DIV_NUM_W'(3276800);
    assign v_num  = {1'b0, mul_p[46:0], 6'd0} + {31'd0, r_dt[ELAPSED_W-1:1]};

    // Offset, relative altitude and altitude low-pass; halving floors.
    assign ofs_sum  = 34'(r_ofs) + 34'(r_raw);
    assign rel_val  = 34'(r_raw) - 34'(r_ofs);
    assign alt_sum  = 35'(r_fa) + 35'(r_rel);
    assign alt_half = $signed(alt_sum[34:1]);
    assign diff     = 33'(r_fa) - 33'(r_prev);

    // Signed quotients and magnitudes for the rate filter.
    assign q_pos   = $signed({2'b00, div_quot});
    assign q_negv  = -q_pos;
    assign acc_abs = r_acc[39] ? $unsigned(-r_acc) : $unsigned(r_acc);
    assign p_term  = $signed({1'b0, mul_p[38:0]});
    assign fr_abs  = abs32(r_fr);
    assign v_abs   = abs32(r_v);

    // Next state, unit control and datapath updates.
    always_comb begin
        n_state     = r_state;
        n_m         = r_m;
        n_neg       = r_neg;
        n_dt        = r_dt;
        n_temp      = r_temp;
        n_q         = r_q;
        n_s         = r_s;
        n_c         = r_c;
        n_raw       = r_raw;
        n_rel       = r_rel;
        n_vneg      = r_vneg;
        n_md        = r_md;
        n_v         = r_v;
        n_acc       = r_acc;
        n_rneg      = r_rneg;
        n_ofs       = r_ofs;
        n_fa        = r_fa;
        n_prev      = r_prev;
        n_fr        = r_fr;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out_alt   = r_out_alt;
        n_out_rate  = r_out_rate;
        n_out_temp  = r_out_temp;
        mul_a       = '0;
        mul_b       = '0;
        div_start   = 1'b0;
        div_num     = '0;
        div_den     = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_sample.valid) begin
                    n_m     = in_m;
                    n_neg   = in_gt;
                    n_temp  = i_sample.temperature;
                    n_dt    = (i_sample.elapsed_us == '0) ? ELAPSED_W'(1)
                                                          : i_sample.elapsed_us;
                    n_state = ST_Q_DIV;
                end
            end
            // q = m/64000 in Q16.
            ST_Q_DIV: begin
                div_start = 1'b1;
                div_num   = q_num;
                div_den   = DIV_DEN_W'(1000);
                n_state   = ST_Q_WAIT;
            end
            ST_Q_WAIT: begin
                if (div_done) begin
                    n_q     = div_quot[PRESSURE_W-1:0];
                    n_state = ST_SQ_MUL;
                end
            end
            // Square and cube in Q16.
            ST_SQ_MUL: begin
                mul_a   = MUL_A_W'(r_q);
                mul_b   = MUL_B_W'(r_q);
                n_state = ST_SQ_CAP;
            end
            ST_SQ_CAP: begin
                n_s     = p_rnd[45:16];
                n_state = ST_CU_MUL;
            end
            ST_CU_MUL: begin
                mul_a   = MUL_A_W'(r_s);
                mul_b   = MUL_B_W'(r_q);
                n_state = ST_CU_CAP;
            end
            ST_CU_CAP: begin
                n_c     = p_rnd[52:16];
                n_state = ST_CT_MUL;
            end
            // Cube term 13.12 * c / 65536, rounded half up.
            ST_CT_MUL: begin
                mul_a   = MUL_A_W'(r_c);
                mul_b   = MUL_B_W'(1312);
                n_state = ST_CT_DIV;
            end
            ST_CT_DIV: begin
                div_start = 1'b1;
                div_num   = ct_num;
                div_den   = DIV_DEN_W'(6553600);
                n_state   = ST_CT_WAIT;
            end
            ST_CT_WAIT: begin
                if (div_done) begin
                    n_raw   = r_neg ? -$signed({1'b0, raw_mag}) : $signed({1'b0, raw_mag});
                    n_state = ST_OFS;
                end
            end
            ST_OFS: begin
                n_ofs   = ofs_sum[32:1];
                n_state = ST_REL;
            end
            ST_REL: begin
                n_rel   = rel_val;
                n_state = ST_ALT;
            end
            ST_ALT: begin
                n_fa    = sat_s32(WIDE_W'(alt_half));
                n_state = ST_DIFF;
            end
            ST_DIFF: begin
                n_vneg  = diff[32];
                n_md    = diff[32] ? $unsigned(-diff) : $unsigned(diff);
                n_prev  = r_fa;
                n_state = ST_V_MUL;
            end
            // Speed: |diff| * 15625 * 64 / dt, rounded, then saturated.
            ST_V_MUL: begin
                mul_a   = MUL_A_W'(r_md);
                mul_b   = MUL_B_W'(15625);
                n_state = ST_V_DIV;
            end
            ST_V_DIV: begin
                div_start = 1'b1;
                div_num   = v_num;
                div_den   = r_dt;
                n_state   = ST_V_WAIT;
            end
            ST_V_WAIT: begin
                if (div_done) begin
                    n_v     = sat_s32(r_vneg ? q_negv : q_pos);
                    n_state = ST_R1_MUL;
                end
            end
            // Rate filter: (65 * rate + 35 * v) / 100, rounded.
            ST_R1_MUL: begin
                mul_a   = MUL_A_W'(fr_abs);
                mul_b   = MUL_B_W'(65);
                n_state = ST_R1_CAP;
            end
            ST_R1_CAP: begin
                n_acc   = r_fr[RESULT_W-1] ? -p_term : p_term;
                n_state = ST_R2_MUL;
            end
            ST_R2_MUL: begin
                mul_a   = MUL_A_W'(v_abs);
                mul_b   = MUL_B_W'(35);
                n_state = ST_R2_CAP;
            end
            ST_R2_CAP: begin
                n_acc   = r_v[RESULT_W-1] ? (r_acc - p_term) : (r_acc + p_term);
                n_state = ST_R_DIV;
            end
            ST_R_DIV: begin
                div_start = 1'b1;
                div_num   = DIV_NUM_W'(acc_abs) + DIV_NUM_W'(50);
                div_den   = DIV_DEN_W'(100);
                n_rneg    = r_acc[39];
                n_state   = ST_R_WAIT;
            end
            ST_R_WAIT: begin
                if (div_done) begin
                    n_fr    = sat_s32(r_rneg ? q_negv : q_pos);
                    n_state = ST_OUT;
                end
            end
            // Hand the result to the output register once it is free.
            ST_OUT: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid = 1'b1;
                    n_out_alt   = r_fa;
                    n_out_rate  = r_fr;
                    n_out_temp  = r_temp;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Filter state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ofs       <= '0;
            r_fa        <= '0;
            r_prev      <= '0;
            r_fr        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_ofs       <= n_ofs;
            r_fa        <= n_fa;
            r_prev      <= n_prev;
            r_fr        <= n_fr;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and output payload registers.
    always_ff @(posedge i_clk) begin
        r_m        <= n_m;
        r_neg      <= n_neg;
        r_dt       <= n_dt;
        r_temp     <= n_temp;
        r_q        <= n_q;
        r_s        <= n_s;
        r_c        <= n_c;
        r_raw      <= n_raw;
        r_rel      <= n_rel;
        r_vneg     <= n_vneg;
        r_md       <= n_md;
        r_v        <= n_v;
        r_acc      <= n_acc;
        r_rneg     <= n_rneg;
        r_out_alt  <= n_out_alt;
        r_out_rate <= n_out_rate;
        r_out_temp <= n_out_temp;
    end

    assign i_sample.ready           = (r_state == ST_IDLE);
    assign o_result.valid           = r_out_valid;
    assign o_result.altitude        = r_out_alt;
    assign o_result.climb_rate      = r_out_rate;
    assign o_result.temperature_out = r_out_temp;

endmodule

### hw/rtl/bavf_mul.sv
`timescale 1ns / 1ps

module bavf_mul (
    input  logic                          i_clk,
    input  logic [bavf_pkg::MUL_A_W-1:0]  i_a,
    input  logic [bavf_pkg::MUL_B_W-1:0]  i_b,
    output logic [bavf_pkg::MUL_P_W-1:0]  o_p
);
    import bavf_pkg::*;

    logic [MUL_P_W-1:0] r_p;

    // Unsigned product, registered so the next step starts from a flop.
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

### hw/rtl/bavf_div.sv
`timescale 1ns / 1ps

module bavf_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [bavf_pkg::DIV_NUM_W-1:0]  i_num,
    input  logic [bavf_pkg::DIV_DEN_W-1:0]  i_den,
    output logic                            o_done,
    output logic [bavf_pkg::DIV_NUM_W-1:0]  o_quot
);
    import bavf_pkg::*;

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [DIV_CNT_W-1:0]  r_cnt, n_cnt;
    logic [DIV_NUM_W-1:0]  r_work, n_work;
    logic [DIV_DEN_W-1:0]  r_rem, n_rem;
    logic [DIV_DEN_W-1:0]  r_den, n_den;

    logic [DIV_DEN_W:0]    t1, t2;
    logic                  ge1, ge2;
    logic [DIV_DEN_W-1:0]  rem1, rem2;

    // Two restoring steps per cycle; the numerator shifts out at the top while
    // quotient bits shift in at the bottom.
    assign t1   = {r_rem, r_work[DIV_NUM_W-1]};
    assign ge1  = t1 >= {1'b0, r_den};
    assign rem1 = ge1 ? DIV_DEN_W'(t1 - {1'b0, r_den}) : t1[DIV_DEN_W-1:0];
    assign t2   = {rem1, r_work[DIV_NUM_W-2]};
    assign ge2  = t2 >= {1'b0, r_den};
    assign rem2 = ge2 ? DIV_DEN_W'(t2 - {1'b0, r_den}) : t2[DIV_DEN_W-1:0];

    // Iteration control.
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_work = r_work;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CNT_W'(DIV_STEPS - 1);
            n_work = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            n_work = {r_work[DIV_NUM_W-3:0], ge1, ge2};
            n_rem  = rem2;
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_work <= n_work;
        r_rem  <= n_rem;
        r_den  <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_work;

endmodule

### hw/rtl/bavf_checker.sv
`timescale 1ns / 1ps
`include "baro_altitude_velocity_filter_top_assert.svh"

module bavf_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [bavf_pkg::RESULT_W-1:0] i_out_altitude,
    input  logic signed [bavf_pkg::RESULT_W-1:0] i_out_climb_rate,
    input  logic signed [bavf_pkg::TEMP_W-1:0]   i_out_temperature
);
    import bavf_pkg::*;

    // Reset empties the output register.
    `BAVF_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !i_out_valid, "result valid after reset")

    // A taken sample keeps the block busy on the following cycle.
    `BAVF_ASSERT(a_busy_after_take, i_in_valid && i_in_ready |=> !i_in_ready, "ready stayed high after a request")

    // A new result only appears right after a point at which the block could not take a sample.
    `BAVF_ASSERT(a_result_from_busy, $rose(i_out_valid) |-> !$past(i_in_ready), "result appeared while idle")

    // A stalled result holds its value.
    `BAVF_ASSERT(a_result_held, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_altitude) && $stable(i_out_climb_rate) && $stable(i_out_temperature), "stalled result changed")

endmodule

bind baro_altitude_velocity_filter_top bavf_checker u_bavf_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_sample.valid),
    .i_in_ready        (i_sample.ready),
    .i_out_valid       (o_result.valid),
    .i_out_ready       (o_result.ready),
    .i_out_altitude    (o_result.altitude),
    .i_out_climb_rate  (o_result.climb_rate),
    .i_out_temperature (o_result.temperature_out)
);
